### hdl/kotc_pkg.sv
// Shared constants and character-class functions for the keyword/operator token classifier.
package kotc_pkg;

	localparam int unsigned KW_NUM   = 11;
	localparam int unsigned KW_CHARS = 6;
	localparam int unsigned CNT_W    = 3;

	// Keyword spellings, first character in the top byte, zero padded.
	localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_NUM] = '{
		{"bool", 16'h0}, {"else", 16'h0}, {"false", 8'h0}, {"func", 16'h0},
		{"if", 32'h0}, {"int", 24'h0}, {"new", 24'h0}, {"return"},
		{"struct"}, {"true", 16'h0}, {"while", 8'h0}
	};
	localparam logic [CNT_W-1:0] KW_LEN [KW_NUM] = '{
		3'd4, 3'd4, 3'd5, 3'd4, 3'd2, 3'd3, 3'd3, 3'd6, 3'd6, 3'd4, 3'd5
	};

	localparam logic [5:0] TK_UNDEF   = 6'd0;
	localparam logic [5:0] TK_ASSIGN  = 6'd12;
	localparam logic [5:0] TK_EQ      = 6'd13;
	localparam logic [5:0] TK_NOT     = 6'd14;
	localparam logic [5:0] TK_NE      = 6'd15;
	localparam logic [5:0] TK_LT      = 6'd16;
	localparam logic [5:0] TK_LE      = 6'd17;
	localparam logic [5:0] TK_GT      = 6'd18;
	localparam logic [5:0] TK_GE      = 6'd19;
	localparam logic [5:0] TK_AND     = 6'd20;
	localparam logic [5:0] TK_OR      = 6'd21;
	localparam logic [5:0] TK_PLUS    = 6'd22;
	localparam logic [5:0] TK_MINUS   = 6'd23;
	localparam logic [5:0] TK_STAR    = 6'd24;
	localparam logic [5:0] TK_SLASH   = 6'd25;
	localparam logic [5:0] TK_PERCENT = 6'd26;
	localparam logic [5:0] TK_COLON   = 6'd27;
	localparam logic [5:0] TK_COMMA   = 6'd28;
	localparam logic [5:0] TK_LBRACK  = 6'd29;
	localparam logic [5:0] TK_RBRACK  = 6'd30;
	localparam logic [5:0] TK_LPAREN  = 6'd31;
	localparam logic [5:0] TK_RPAREN  = 6'd32;
	localparam logic [5:0] TK_LBRACE  = 6'd33;
	localparam logic [5:0] TK_RBRACE  = 6'd34;
	localparam logic [5:0] TK_DOT     = 6'd35;
	localparam logic [5:0] TK_SEMI    = 6'd36;
	localparam logic [5:0] TK_EOI     = 6'd37;

	localparam logic [7:0] CH_EQ   = 8'h3D;
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_BAR  = 8'h7C;
	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_LT   = 8'h3C;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_ident(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
		       (c >= "0" && c <= "9") || (c == "_");
	endfunction

	// Kind of a token that is complete after one character, else TK_UNDEF.
	function automatic logic [5:0] single_kind(input logic [7:0] c);
		logic [5:0] k;
		k = TK_UNDEF;
		unique case (c)
			"+":     k = TK_PLUS;
			"-":     k = TK_MINUS;
			"*":     k = TK_STAR;
			"/":     k = TK_SLASH;
			"%":     k = TK_PERCENT;
			":":     k = TK_COLON;
			",":     k = TK_COMMA;
			"[":     k = TK_LBRACK;
			"]":     k = TK_RBRACK;
			"(":     k = TK_LPAREN;
			")":     k = TK_RPAREN;
			"{":     k = TK_LBRACE;
			"}":     k = TK_RBRACE;
			".":     k = TK_DOT;
			";":     k = TK_SEMI;
			CH_NUL:  k = TK_EOI;
			default: k = TK_UNDEF;
		endcase
		return k;
	endfunction

	function automatic logic is_pair_lead(input logic [7:0] c);
		return (c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT) ||
		       (c == CH_AMP) || (c == CH_BAR);
	endfunction

	// Kind of a two-character operator candidate given its lead and next byte.
	function automatic logic [5:0] pair_kind(input logic [7:0] lead, input logic [7:0] c);
		logic [5:0] k;
		k = TK_UNDEF;
		unique case (lead)
			CH_EQ:   k = (c == CH_EQ) ? TK_EQ : TK_ASSIGN;
			CH_BANG: k = (c == CH_EQ) ? TK_NE : TK_NOT;
			CH_LT:   k = (c == CH_EQ) ? TK_LE : TK_LT;
			CH_GT:   k = (c == CH_EQ) ? TK_GE : TK_GT;
			CH_AMP:  k = (c == CH_AMP) ? TK_AND : TK_UNDEF;
			CH_BAR:  k = (c == CH_BAR) ? TK_OR : TK_UNDEF;
			default: k = TK_UNDEF;
		endcase
		return k;
	endfunction

endpackage

### hdl/keyword_operator_token_classifier_unit.sv
// Top level of the keyword/operator token classifier: input register, match state, result register.
//
//   channel | signals                          | direction | content
//   --------+----------------------------------+-----------+---------------------------
//   in      | in_valid, in_stall, text_byte,   | into unit | one text byte per transfer
//           | start_query                      |           |
//   out     | out_valid, out_stall, token_kind | from unit | at most one kind per query
//
// One byte per cycle unless stalled; the deciding byte passes the input, then the result register.
// The first token is tracked as a keyword candidate mask, a held count and the lead byte,
// updated once per byte between the input register and the result register.
// arst_n clears the pipeline valids and returns the scan to idle.
// A stalled result holds; in_stall rises only when a deciding byte waits on a full result.
module keyword_operator_token_classifier_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] text_byte,
	input  logic       start_query,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [5:0] token_kind
);

	localparam int unsigned NK = kotc_pkg::KW_NUM;
	localparam int unsigned CW = kotc_pkg::CNT_W;

	typedef enum logic [1:0] {PH_IDLE, PH_SCAN, PH_DONE} phase_t;

	phase_t          phase_q;
	logic [CW-1:0]   cnt_q;
	logic [7:0]      lead_q;
	logic [NK-1:0]   alive_q;

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            start_s1;

	logic            out_valid_q;
	logic [5:0]      kind_q;

	logic            scanning;
	logic [CW-1:0]   n;
	logic            emit;
	logic [5:0]      kind;
	logic            hold;
	logic [NK-1:0]   alive_d;
	logic            out_free;
	logic            step;
	logic            kw_hit;

	always_comb begin
		logic [5:0] sk;
		logic [5:0] base;
		scanning = start_s1 || (phase_q == PH_SCAN);
		n        = start_s1 ? '0 : cnt_q;
		emit     = 1'b0;
		hold     = 1'b0;
		kind     = kotc_pkg::TK_UNDEF;
		alive_d  = '0;
		kw_hit   = 1'b0;
		base     = '0;
		sk       = kotc_pkg::single_kind(byte_s1);
		if (scanning) begin
			if (n == '0) begin
				if (kotc_pkg::is_blank(byte_s1)) begin
					emit = 1'b0;
				end else if (kotc_pkg::is_pair_lead(byte_s1)) begin
					hold = 1'b1;
				end else if (sk != kotc_pkg::TK_UNDEF) begin
					emit = 1'b1;
					kind = sk;
				end else begin
					for (int k = 0; k < NK; k++)
						alive_d[k] = (kotc_pkg::KW_TEXT[k][8*kotc_pkg::KW_CHARS-1 -: 8]
						              == byte_s1);
					hold = |alive_d;
					emit = ~hold;
				end
			end else if (alive_q == '0) begin
				// held lead of a two-character operator
				emit = 1'b1;
				kind = kotc_pkg::pair_kind(lead_q, byte_s1);
			end else begin
				for (int k = NK - 1; k >= 0; k--) begin
					base = 6'(8 * (kotc_pkg::KW_CHARS - 1)) - {n, 3'b000};
					if (alive_q[k] && n < kotc_pkg::KW_LEN[k])
						alive_d[k] = (kotc_pkg::KW_TEXT[k][base +: 8] == byte_s1);
					// lowest table index wins
					if (alive_q[k] && n == kotc_pkg::KW_LEN[k] &&
					    !kotc_pkg::is_ident(byte_s1)) begin
						kw_hit = 1'b1;
						kind   = 6'(k + 1);
					end
				end
				if (kw_hit) begin
					emit = 1'b1;
				end else if (alive_d != '0) begin
					hold = 1'b1;
				end else begin
					emit = 1'b1;
					kind = kotc_pkg::TK_UNDEF;
				end
			end
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign step     = valid_s1 && (!emit || out_free);
	assign in_stall = valid_s1 && emit && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			phase_q     <= PH_IDLE;
			cnt_q       <= '0;
			alive_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (step && scanning) begin
				if (emit) begin
					phase_q <= PH_DONE;
					cnt_q   <= '0;
					alive_q <= '0;
				end else if (hold) begin
					phase_q <= PH_SCAN;
					cnt_q   <= n + 1'b1;
					alive_q <= alive_d;
				end else begin
					// leading blank
					phase_q <= PH_SCAN;
					cnt_q   <= '0;
					alive_q <= '0;
				end
			end
			if (step && emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1  <= text_byte;
			start_s1 <= start_query;
		end
		if (step && scanning && hold && n == '0) begin
			lead_q <= byte_s1;
		end
		if (step && emit) begin
			kind_q <= kind;
		end
	end

	assign out_valid  = out_valid_q;
	assign token_kind = kind_q;

endmodule

### verif/keyword_operator_token_classifier_unit_tb.sv
// Testbench for the keyword/operator token classifier: directed texts, then random queries.
`timescale 1ns / 100ps

module testbench;

	localparam int BYTES_WANTED = 1250;
	localparam int STALL_HOLD   = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int HOLD_MAX     = 6;
	localparam int PENDING      = -1;
	localparam int NO_TYPED     = -1;

	localparam logic [5:0] KW_BOOL   = 6'd1;
	localparam logic [5:0] KW_ELSE   = 6'd2;
	localparam logic [5:0] KW_FALSE  = 6'd3;
	localparam logic [5:0] KW_FUNC   = 6'd4;
	localparam logic [5:0] KW_IF     = 6'd5;
	localparam logic [5:0] KW_INT    = 6'd6;
	localparam logic [5:0] KW_NEW    = 6'd7;
	localparam logic [5:0] KW_RETURN = 6'd8;
	localparam logic [5:0] KW_STRUCT = 6'd9;
	localparam logic [5:0] KW_TRUE   = 6'd10;
	localparam logic [5:0] KW_WHILE  = 6'd11;

	localparam logic [5:0] KEYWORD_KIND [11] = '{
		KW_BOOL, KW_ELSE, KW_FALSE, KW_FUNC, KW_IF, KW_INT,
		KW_NEW, KW_RETURN, KW_STRUCT, KW_TRUE, KW_WHILE
	};

	localparam string IDENT_POOL = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
	localparam string OP_POOL    = "=!<>&|+-*/%:,[](){}.;";
	localparam string PAIR_POOL  = "=&|";

	typedef enum logic [1:0] {SCAN_IDLE, SCAN_ACTIVE, SCAN_DONE} scan_state_t;

	typedef struct {
		string txt;
		bit    lead_start;
		bit    nul_tail;
		int    want;
	} text_row_t;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_stall;
	logic [7:0] text_byte   = 8'h00;
	logic       start_query = 1'b0;
	logic       out_valid;
	logic       out_stall   = 1'b0;
	logic [5:0] token_kind;

	// predictor state
	scan_state_t scan_state = SCAN_IDLE;
	logic [7:0]  held_bytes [HOLD_MAX];
	int          held_len   = 0;

	logic [5:0] kinds_due [$];
	logic [5:0] due_kind;
	int         errors      = 0;
	int         kinds_seen  = 0;
	int         sent_bytes  = 0;
	int         cycles      = 0;
	bit         in_random   = 0;
	bit         hold_done   = 0;

	text_row_t directed_rows [26] = '{
		'{"x", 1'b0, 1'b0, NO_TYPED},
		'{"if", 1'b1, 1'b1, KW_IF},
		'{"\t\n\013\014\015 whilex", 1'b1, 1'b0, kotc_pkg::TK_UNDEF},
		'{"bool ", 1'b1, 1'b0, KW_BOOL},
		'{"else;", 1'b1, 1'b0, KW_ELSE},
		'{"false(", 1'b1, 1'b0, KW_FALSE},
		'{"func\377", 1'b1, 1'b0, KW_FUNC},
		'{"int)", 1'b1, 1'b0, KW_INT},
		'{"new.", 1'b1, 1'b0, KW_NEW},
		'{"return{", 1'b1, 1'b0, KW_RETURN},
		'{"struct}", 1'b1, 1'b0, KW_STRUCT},
		'{"true,", 1'b1, 1'b0, KW_TRUE},
		'{"while[", 1'b1, 1'b0, KW_WHILE},
		'{"ret", 1'b1, 1'b1, kotc_pkg::TK_UNDEF},
		'{"=", 1'b1, 1'b1, kotc_pkg::TK_ASSIGN},
		'{"==", 1'b1, 1'b0, kotc_pkg::TK_EQ},
		'{"!=", 1'b1, 1'b0, kotc_pkg::TK_NE},
		'{"&|", 1'b1, 1'b0, kotc_pkg::TK_UNDEF},
		'{"||", 1'b1, 1'b0, kotc_pkg::TK_OR},
		'{"<=", 1'b1, 1'b0, kotc_pkg::TK_LE},
		'{">a", 1'b1, 1'b0, kotc_pkg::TK_GT},
		'{"", 1'b1, 1'b1, kotc_pkg::TK_EOI},
		'{"\377", 1'b1, 1'b0, kotc_pkg::TK_UNDEF},
		'{"retu", 1'b1, 1'b0, NO_TYPED},
		'{"+", 1'b1, 1'b0, kotc_pkg::TK_PLUS},
		'{"abc", 1'b0, 1'b0, NO_TYPED}
	};

	keyword_operator_token_classifier_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_byte   (text_byte),
		.start_query (start_query),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.token_kind  (token_kind)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic string keyword_text(input int k);
		case (k)
			0:       return "bool";
			1:       return "else";
			2:       return "false";
			3:       return "func";
			4:       return "if";
			5:       return "int";
			6:       return "new";
			7:       return "return";
			8:       return "struct";
			9:       return "true";
			default: return "while";
		endcase
	endfunction

	function automatic bit blank_byte(input logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic bit word_byte(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
		       (c >= "0" && c <= "9") || c == "_";
	endfunction

	// Kind of the token in seq[0..n-1], or PENDING while more bytes could change it.
	function automatic int token_of(input logic [7:0] seq [HOLD_MAX+1], input int n);
		string w;
		int    wl;
		bit    bad;
		bit    pending;
		pending = 0;
		if (n < 2 && (seq[0] == kotc_pkg::CH_EQ || seq[0] == kotc_pkg::CH_BANG ||
		              seq[0] == kotc_pkg::CH_LT || seq[0] == kotc_pkg::CH_GT ||
		              seq[0] == kotc_pkg::CH_AMP || seq[0] == kotc_pkg::CH_BAR))
			return PENDING;
		case (seq[0])
			kotc_pkg::CH_EQ:
				return (seq[1] == kotc_pkg::CH_EQ) ? int'(kotc_pkg::TK_EQ) :
				                                     int'(kotc_pkg::TK_ASSIGN);
			kotc_pkg::CH_BANG:
				return (seq[1] == kotc_pkg::CH_EQ) ? int'(kotc_pkg::TK_NE) :
				                                     int'(kotc_pkg::TK_NOT);
			kotc_pkg::CH_LT:
				return (seq[1] == kotc_pkg::CH_EQ) ? int'(kotc_pkg::TK_LE) :
				                                     int'(kotc_pkg::TK_LT);
			kotc_pkg::CH_GT:
				return (seq[1] == kotc_pkg::CH_EQ) ? int'(kotc_pkg::TK_GE) :
				                                     int'(kotc_pkg::TK_GT);
			kotc_pkg::CH_AMP:
				return (seq[1] == kotc_pkg::CH_AMP) ? int'(kotc_pkg::TK_AND) :
				                                      int'(kotc_pkg::TK_UNDEF);
			kotc_pkg::CH_BAR:
				return (seq[1] == kotc_pkg::CH_BAR) ? int'(kotc_pkg::TK_OR) :
				                                      int'(kotc_pkg::TK_UNDEF);
			"+":     return kotc_pkg::TK_PLUS;
			"-":     return kotc_pkg::TK_MINUS;
			"*":     return kotc_pkg::TK_STAR;
			"/":     return kotc_pkg::TK_SLASH;
			"%":     return kotc_pkg::TK_PERCENT;
			":":     return kotc_pkg::TK_COLON;
			",":     return kotc_pkg::TK_COMMA;
			"[":     return kotc_pkg::TK_LBRACK;
			"]":     return kotc_pkg::TK_RBRACK;
			"(":     return kotc_pkg::TK_LPAREN;
			")":     return kotc_pkg::TK_RPAREN;
			"{":     return kotc_pkg::TK_LBRACE;
			"}":     return kotc_pkg::TK_RBRACE;
			".":     return kotc_pkg::TK_DOT;
			";":     return kotc_pkg::TK_SEMI;
			kotc_pkg::CH_NUL: return kotc_pkg::TK_EOI;
			default: ;
		endcase
		for (int k = 0; k < 11; k++) begin
			w = keyword_text(k);
			wl = w.len();
			if (w[0] != seq[0])
				continue;
			bad = 0;
			for (int i = 1; i < wl && i < n; i++)
				if (seq[i] != w[i])
					bad = 1;
			if (bad)
				continue;
			if (n <= wl) begin
				pending = 1;
				continue;
			end
			// a keyword must not run on into an identifier
			if (!word_byte(seq[wl]))
				return KEYWORD_KIND[k];
		end
		return pending ? PENDING : int'(kotc_pkg::TK_UNDEF);
	endfunction

	// Advances the predicted scan by one byte; returns 1 when a kind is emitted.
	function automatic bit classify_byte(input logic [7:0] c, input bit s,
	                                     output logic [5:0] kind);
		logic [7:0] seq [HOLD_MAX+1];
		int         n;
		int         r;
		kind = kotc_pkg::TK_UNDEF;
		if (s) begin
			scan_state = SCAN_ACTIVE;
			held_len = 0;
		end
		if (scan_state != SCAN_ACTIVE)
			return 0;
		if (held_len == 0 && blank_byte(c))
			return 0;
		n = held_len;
		for (int i = 0; i < HOLD_MAX + 1; i++)
			seq[i] = 8'h00;
		for (int i = 0; i < n; i++)
			seq[i] = held_bytes[i];
		seq[n] = c;
		r = token_of(seq, n + 1);
		if (r == PENDING) begin
			if (n < HOLD_MAX) begin
				held_bytes[n] = c;
				held_len = n + 1;
				return 0;
			end
			r = kotc_pkg::TK_UNDEF;
		end
		scan_state = SCAN_DONE;
		held_len = 0;
		kind = r[5:0];
		return 1;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 70)
			return 0;
		if (p < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] pick_blank();
		int n;
		n = $urandom_range(0, 5);
		return (n == 5) ? 8'd32 : 8'(9 + n);
	endfunction

	function automatic logic [7:0] pick_from(input string pool);
		return pool[$urandom_range(0, pool.len() - 1)];
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit s, input int typed, input bit quiet);
		int         gap;
		logic [5:0] kind;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		text_byte   <= b;
		start_query <= s;
		do @(posedge clk); while (in_stall);
		if (classify_byte(b, s, kind))
			kinds_due.push_back((typed >= 0) ? typed[5:0] : kind);
		sent_bytes++;
	endtask

	task automatic random_query();
		logic [7:0] q [$];
		string      w;
		int         cut;
		int         p;
		bit         quiet;
		quiet = ($urandom_range(0, 3) == 0);
		// noise: loose bytes, an occasional start among them
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 8))
				send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
				          NO_TYPED, quiet);
			return;
		end
		if ($urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 3)) q.push_back(pick_blank());
		p = $urandom_range(0, 99);
		if (p < 45) begin
			w = keyword_text($urandom_range(0, 10));
			cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, w.len()) : w.len();
			for (int i = 0; i < cut; i++)
				q.push_back(($urandom_range(0, 7) == 0) ? pick_from(IDENT_POOL) : w[i]);
			case ($urandom_range(0, 3))
				0:       q.push_back(pick_from(IDENT_POOL));
				1:       q.push_back(8'($urandom_range(0, 255)));
				2:       q.push_back(pick_from(OP_POOL));
				default: q.push_back(($urandom_range(0, 1) == 0) ? kotc_pkg::CH_NUL :
				                     pick_blank());
			endcase
		end else if (p < 75) begin
			q.push_back(pick_from(OP_POOL));
			q.push_back(($urandom_range(0, 1) == 0) ? pick_from(PAIR_POOL) :
			            8'($urandom_range(0, 255)));
		end else if (p < 82) begin
			q.push_back(kotc_pkg::CH_NUL);
		end else begin
			repeat ($urandom_range(1, 7))
				q.push_back(($urandom_range(0, 1) == 0) ? pick_from(IDENT_POOL) :
				            8'($urandom_range(0, 255)));
		end
		repeat ($urandom_range(0, 3)) q.push_back(8'($urandom_range(0, 255)));
		foreach (q[i])
			send_byte(q[i], i == 0, NO_TYPED, quiet);
	endtask

	initial begin
		text_row_t row;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[r]) begin
			row = directed_rows[r];
			for (int i = 0; i < row.txt.len(); i++)
				send_byte(row.txt[i], row.lead_start && i == 0, row.want, 1'b0);
			if (row.nul_tail)
				send_byte(kotc_pkg::CH_NUL, row.lead_start && row.txt.len() == 0,
				          row.want, 1'b0);
		end
		sent_bytes = 0;
		in_random = 1;
		while (sent_bytes < BYTES_WANTED)
			random_query();
		in_valid <= 1'b0;
		while (kinds_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// receiver: random stalls, quiet stretches, and one long hold-off that backs up the input
	initial begin
		int p;
		int len;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!hold_done && in_random && kinds_seen >= 30) begin
				out_stall <= 1'b1;
				repeat (STALL_HOLD) @(posedge clk);
				hold_done = 1;
			end else begin
				p = $urandom_range(0, 99);
				if (p < 5) begin
					out_stall <= 1'b0;
					repeat ($urandom_range(20, 60)) @(posedge clk);
				end else begin
					if (p < 60)
						len = 0;
					else if (p < 92)
						len = $urandom_range(1, 3);
					else if (p < 98)
						len = $urandom_range(4, 12);
					else
						len = $urandom_range(20, 40);
					if (len == 0) begin
						out_stall <= 1'b0;
						@(posedge clk);
					end else begin
						out_stall <= 1'b1;
						repeat (len) @(posedge clk);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (kinds_due.size() == 0) begin
				$error("token_kind: no result expected, got %0d", token_kind);
				errors++;
			end else begin
				due_kind = kinds_due.pop_front();
				if (token_kind !== due_kind) begin
					$error("token_kind: expected %0d, got %0d", due_kind, token_kind);
					errors++;
				end
				kinds_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

endmodule
